// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an expression at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("assertion failed");

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/psi_pkg.sv =====
// Package with constants and payload types of the playout sorted insert block.
package psi_pkg;

  localparam int POOL_SLOTS = 64;
  localparam int SLOT_W     = $clog2(POOL_SLOTS);
  localparam int LINK_W     = SLOT_W + 1;
  localparam int CNT_W      = $clog2(POOL_SLOTS + 1);
  localparam int SEQ_W      = 16;
  localparam int KEY_W      = 32;

  localparam logic [LINK_W-1:0] NO_LINK = LINK_W'(POOL_SLOTS);

  typedef enum logic [1:0] {
    ST_HEAD     = 2'd0,
    ST_DUP      = 2'd1,
    ST_MISORDER = 2'd2
  } status_e;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [SEQ_W-1:0]  seq_number;
    logic [KEY_W-1:0]  cycle_base;
  } psi_req_t;

  typedef struct packed {
    status_e          status;
    logic [CNT_W-1:0] held_count;
  } psi_rsp_t;

endpackage

// ===== rtl/psi_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module psi_ram #(
  parameter int Width = 8,
  parameter int Depth = 64,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/playout_sorted_insert_top.sv =====
// Top level of the playout sorted insert block: sequencer, list registers and link RAMs.
//
// Usage:
//   A request (slot, seq_number, cycle_base) is taken at a rising edge with start high
//   and busy low. The slot is linked into a list held in descending key order; the
//   result (status, held_count) appears on rsp_o for exactly one cycle with done_o high.
//   The receiver cannot hold results off; a result is taken in the cycle it is shown.
// Operation:
//   A request for a slot that is already linked is refused with done_o high in the
//   next cycle and busy stays low. Otherwise the walk visits one list entry per cycle
//   through the registered read port of the link RAMs (one add and compare of keys per
//   cycle), then states StLinkA and StLinkB write the links. A free slot leaves at most
//   POOL_SLOTS - 1 entries to pass. The next request can be taken in the cycle done_o
//   is high.
// Reset:
//   rst_ni clears the list to empty, the count and the shared cycle to zero and all
//   slot-linked flags. The link RAMs need no clearing: only data of linked slots is used.
`include "assert_macros.svh"

module playout_sorted_insert_top import psi_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  psi_req_t req_i,
  output logic     done_o,
  output psi_rsp_t rsp_o
);

  typedef enum logic [1:0] {
    StIdle,
    StWalk,
    StLinkA,
    StLinkB
  } state_e;

  state_e                 state_q, state_d;
  logic [SLOT_W-1:0]      slot_q;
  logic [SEQ_W-1:0]       seq_q;
  logic [KEY_W-1:0]       base_q;
  logic [KEY_W-1:0]       key_q, key_d;
  logic [LINK_W-1:0]      cur_q, cur_d;
  logic [LINK_W-1:0]      p_q, p_d;
  logic [CNT_W-1:0]       steps_q, steps_d;
  logic [LINK_W-1:0]      head_q, head_d;
  logic [LINK_W-1:0]      tail_q, tail_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [KEY_W-1:0]       shared_q, shared_d;
  logic [POOL_SLOTS-1:0]  linked_q, linked_d;
  logic                   done_q, done_d;
  psi_rsp_t               rsp_q, rsp_d;
  logic                   load;

  logic                   seq_we, next_we, prev_we;
  logic [SLOT_W-1:0]      seq_waddr, next_waddr, prev_waddr, raddr;
  logic [LINK_W-1:0]      next_wdata, prev_wdata;
  logic [SEQ_W-1:0]       rd_seq;
  logic [LINK_W-1:0]      rd_next, rd_prev;

  logic                   cur_valid, head_case, key_gt, key_eq;
  logic [KEY_W-1:0]       stored_key;

  psi_ram #(.Width(SEQ_W), .Depth(POOL_SLOTS)) u_seq_ram (
    .clk_i   (clk_i),
    .we_i    (seq_we),
    .waddr_i (seq_waddr),
    .wdata_i (seq_q),
    .raddr_i (raddr),
    .rdata_o (rd_seq)
  );

  psi_ram #(.Width(LINK_W), .Depth(POOL_SLOTS)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (next_we),
    .waddr_i (next_waddr),
    .wdata_i (next_wdata),
    .raddr_i (raddr),
    .rdata_o (rd_next)
  );

  psi_ram #(.Width(LINK_W), .Depth(POOL_SLOTS)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prev_we),
    .waddr_i (prev_waddr),
    .wdata_i (prev_wdata),
    .raddr_i (raddr),
    .rdata_o (rd_prev)
  );

  assign cur_valid  = (cur_q != NO_LINK);
  assign head_case  = (cur_q == head_q);
  assign stored_key = KEY_W'(rd_seq) + shared_q;
  assign key_gt     = (stored_key > key_q);
  assign key_eq     = (stored_key == key_q);

  always_comb begin
    state_d    = state_q;
    key_d      = key_q;
    cur_d      = cur_q;
    p_d        = p_q;
    steps_d    = steps_q;
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    shared_d   = shared_q;
    linked_d   = linked_q;
    done_d     = 1'b0;
    rsp_d      = rsp_q;
    load       = 1'b0;
    raddr      = head_q[SLOT_W-1:0];
    seq_we     = 1'b0;
    next_we    = 1'b0;
    prev_we    = 1'b0;
    seq_waddr  = slot_q;
    next_waddr = slot_q;
    prev_waddr = slot_q;
    next_wdata = cur_q;
    prev_wdata = NO_LINK;

    case (state_q)
      StIdle: begin
        if (start) begin
          if (linked_q[req_i.slot]) begin
            done_d           = 1'b1;
            rsp_d.status     = ST_DUP;
            rsp_d.held_count = count_q;
          end else begin
            load    = 1'b1;
            key_d   = KEY_W'(req_i.seq_number) + req_i.cycle_base;
            cur_d   = head_q;
            steps_d = '0;
            state_d = StWalk;
          end
        end
      end
      StWalk: begin
        if (!cur_valid) begin
          p_d     = tail_q;
          state_d = StLinkA;
        end else if (key_gt && steps_q != CNT_W'(POOL_SLOTS)) begin
          cur_d   = rd_next;
          raddr   = rd_next[SLOT_W-1:0];
          steps_d = steps_q + CNT_W'(1);
        end else if (key_eq) begin
          done_d           = 1'b1;
          rsp_d.status     = ST_DUP;
          rsp_d.held_count = count_q;
          state_d          = StIdle;
        end else begin
          p_d     = rd_prev;
          state_d = StLinkA;
        end
      end
      StLinkA: begin
        seq_we     = 1'b1;
        next_we    = 1'b1;
        next_wdata = cur_q;
        prev_we    = 1'b1;
        prev_wdata = head_case ? NO_LINK : p_q;
        state_d    = StLinkB;
      end
      StLinkB: begin
        next_we    = !head_case && (p_q != NO_LINK);
        next_waddr = p_q[SLOT_W-1:0];
        next_wdata = {1'b0, slot_q};
        prev_we    = cur_valid;
        prev_waddr = cur_q[SLOT_W-1:0];
        prev_wdata = {1'b0, slot_q};
        linked_d[slot_q] = 1'b1;
        count_d    = count_q + CNT_W'(1);
        if (head_case) begin
          head_d   = {1'b0, slot_q};
          shared_d = base_q;
        end
        if (!cur_valid) begin
          tail_d = {1'b0, slot_q};
        end
        done_d           = 1'b1;
        rsp_d.status     = head_case ? ST_HEAD : ST_MISORDER;
        rsp_d.held_count = count_q + CNT_W'(1);
        state_d          = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      cur_q    <= NO_LINK;
      steps_q  <= '0;
      head_q   <= NO_LINK;
      tail_q   <= NO_LINK;
      count_q  <= '0;
      shared_q <= '0;
      linked_q <= '0;
      done_q   <= 1'b0;
      rsp_q    <= '{status: ST_HEAD, held_count: '0};
    end else begin
      state_q  <= state_d;
      cur_q    <= cur_d;
      steps_q  <= steps_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      count_q  <= count_d;
      shared_q <= shared_d;
      linked_q <= linked_d;
      done_q   <= done_d;
      rsp_q    <= rsp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      slot_q <= req_i.slot;
      seq_q  <= req_i.seq_number;
      base_q <= req_i.cycle_base;
    end
    key_q <= key_d;
    p_q   <= p_d;
  end

  assign busy   = (state_q != StIdle);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  `ASSERT_ALWAYS(a_count_matches_linked, 32'(count_q) == $countones(linked_q))
  `ASSERT_ALWAYS(a_empty_head, (count_q == '0) == (head_q == NO_LINK))
  `ASSERT_ALWAYS(a_empty_tail, (count_q == '0) == (tail_q == NO_LINK))
  `ASSERT_IMP(a_walk_bound, state_q == StWalk, steps_q <= CNT_W'(POOL_SLOTS))
  `ASSERT_IMP(a_head_insert, done_o && rsp_o.status == ST_HEAD,
              head_q[SLOT_W-1:0] == slot_q && head_q != NO_LINK && shared_q == base_q)

endmodule

// ===== dv/tb_playout_sorted_insert_top.sv =====
// Testbench for the playout sorted insert block: directed table, random requests, predictor.
`timescale 1ns / 100ps

module tb_playout_sorted_insert_top;
  import psi_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_ITEMS  = 590;
  localparam int CALM_ITEMS  = 100;
  localparam int DRAIN_EVERY = 150;
  localparam int DIR_ROWS    = 16;

  typedef struct packed {
    psi_req_t rq;
    logic     typed;
    psi_rsp_t rsp;
  } dir_row_t;

  logic     clk_i  = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start  = 1'b0;
  psi_req_t req_i  = '0;
  logic     busy;
  logic     done_o;
  psi_rsp_t rsp_o;

  // Predicted list state
  logic [SEQ_W-1:0]  held_seq  [POOL_SLOTS];
  logic [LINK_W-1:0] fwd_link  [POOL_SLOTS];
  logic [LINK_W-1:0] back_link [POOL_SLOTS];
  logic              slot_used [POOL_SLOTS];
  logic [LINK_W-1:0] head_at;
  logic [LINK_W-1:0] tail_at;
  logic [KEY_W-1:0]  cycle_reg;
  int                held_total;

  psi_rsp_t outcome_q[$];
  int       mismatches = 0;
  int       cycle_cnt  = 0;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{'{6'd0,  16'd100,    32'd0},           1'b1, '{ST_HEAD,     7'd1}},
    '{'{6'd0,  16'd5,      32'd0},           1'b1, '{ST_DUP,      7'd1}},
    '{'{6'd1,  16'd100,    32'd0},           1'b1, '{ST_DUP,      7'd1}},
    '{'{6'd1,  16'd50,     32'd0},           1'b1, '{ST_MISORDER, 7'd2}},
    '{'{6'd2,  16'd75,     32'd0},           1'b0, '{ST_HEAD,     7'd0}},
    '{'{6'd3,  16'd200,    32'd0},           1'b0, '{ST_HEAD,     7'd0}},
    '{'{6'd63, 16'hFFFF,   32'd0},           1'b0, '{ST_HEAD,     7'd0}},
    '{'{6'd4,  16'd0,      32'd0},           1'b0, '{ST_HEAD,     7'd0}},
    '{'{6'd5,  16'd0,      32'hFFFF_FFFF},   1'b0, '{ST_HEAD,     7'd0}},
    '{'{6'd6,  16'hFFFF,   32'hFFFF_0000},   1'b0, '{ST_HEAD,     7'd0}},
    '{'{6'd7,  16'h8000,   32'h8000_0000},   1'b0, '{ST_HEAD,     7'd0}},
    '{'{6'd8,  16'h5555,   32'h5555_5555},   1'b0, '{ST_HEAD,     7'd0}},
    '{'{6'd9,  16'hAAAA,   32'hAAAA_AAAA},   1'b0, '{ST_HEAD,     7'd0}},
    '{'{6'd62, 16'd1,      32'd1},           1'b0, '{ST_HEAD,     7'd0}},
    '{'{6'd63, 16'd0,      32'd0},           1'b0, '{ST_HEAD,     7'd0}},
    '{'{6'd10, 16'h7FFF,   32'h0000_FFFF},   1'b0, '{ST_HEAD,     7'd0}}
  };

  playout_sorted_insert_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic logic [KEY_W-1:0] stored_key(logic [LINK_W-1:0] s);
    return KEY_W'(held_seq[s[SLOT_W-1:0]]) + cycle_reg;
  endfunction

  function automatic psi_rsp_t insert_outcome(psi_req_t rq);
    logic [KEY_W-1:0]  key;
    logic [LINK_W-1:0] cur;
    logic [LINK_W-1:0] p;
    logic [LINK_W-1:0] me;
    int                steps;
    psi_rsp_t          r;
    r.status = ST_DUP;
    me = LINK_W'(rq.slot);
    if (!slot_used[rq.slot]) begin
      key   = KEY_W'(rq.seq_number) + rq.cycle_base;
      cur   = head_at;
      steps = 0;
      while (cur != NO_LINK && steps < POOL_SLOTS && stored_key(cur) > key) begin
        cur = fwd_link[cur[SLOT_W-1:0]];
        steps++;
      end
      if (!(cur != NO_LINK && stored_key(cur) == key)) begin
        held_seq[rq.slot]  = rq.seq_number;
        slot_used[rq.slot] = 1'b1;
        if (cur == head_at) begin
          fwd_link[rq.slot]  = cur;
          back_link[rq.slot] = NO_LINK;
          if (cur != NO_LINK) back_link[cur[SLOT_W-1:0]] = me;
          else tail_at = me;
          head_at   = me;
          cycle_reg = rq.cycle_base;
          r.status  = ST_HEAD;
        end else if (cur == NO_LINK) begin
          p = tail_at;
          if (p != NO_LINK) fwd_link[p[SLOT_W-1:0]] = me;
          back_link[rq.slot] = p;
          fwd_link[rq.slot]  = NO_LINK;
          tail_at  = me;
          r.status = ST_MISORDER;
        end else begin
          p = back_link[cur[SLOT_W-1:0]];
          if (p != NO_LINK) fwd_link[p[SLOT_W-1:0]] = me;
          back_link[rq.slot]          = p;
          fwd_link[rq.slot]           = cur;
          back_link[cur[SLOT_W-1:0]]  = me;
          r.status = ST_MISORDER;
        end
        held_total++;
      end
    end
    r.held_count = CNT_W'(held_total);
    return r;
  endfunction

  function automatic int pick_slot(logic used);
    int hits[$];
    for (int i = 0; i < POOL_SLOTS; i++) begin
      if (slot_used[i] == used) hits.push_back(i);
    end
    if (hits.size() == 0) return -1;
    return hits[$urandom_range(0, hits.size() - 1)];
  endfunction

  function automatic psi_req_t random_request();
    psi_req_t rq;
    int       free_s;
    int       own_s;
    int       mode;
    free_s = pick_slot(1'b0);
    own_s  = pick_slot(1'b1);
    mode   = $urandom_range(0, 99);
    rq.slot       = '0;
    rq.seq_number = SEQ_W'($urandom);
    rq.cycle_base = $urandom;
    if (own_s >= 0 && (free_s < 0 || mode >= 62)) begin
      rq.slot = SLOT_W'(own_s);
    end else if (own_s >= 0 && mode >= 12) begin
      // free slot whose key collides with a held entry
      rq.slot = SLOT_W'(free_s);
      if (mode[0]) begin
        rq.seq_number = held_seq[own_s];
        rq.cycle_base = cycle_reg;
      end else begin
        rq.cycle_base = cycle_reg + KEY_W'(held_seq[own_s]) - KEY_W'(rq.seq_number);
      end
    end else begin
      rq.slot = SLOT_W'(free_s);
      case ($urandom_range(0, 5))
        0, 1, 2: rq.cycle_base = cycle_reg;
        3: begin
          rq.cycle_base = cycle_reg;
          if (own_s >= 0) begin
            rq.seq_number = mode[0] ? held_seq[own_s] + 16'd1 : held_seq[own_s] - 16'd1;
          end
        end
        4: ;
        default: rq.cycle_base = cycle_reg + (KEY_W'($urandom_range(0, 3)) << 16);
      endcase
    end
    return rq;
  endfunction

  task automatic issue_request(input psi_req_t rq, input logic typed,
                               input psi_rsp_t typed_rsp, input logic may_idle);
    psi_rsp_t predicted;
    start <= 1'b1;
    req_i <= rq;
    do @(posedge clk_i); while (busy);
    predicted = insert_outcome(rq);
    outcome_q.push_back(typed ? typed_rsp : predicted);
    if (may_idle && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (outcome_q.size() != 0);
  endtask

  always @(posedge clk_i) begin
    psi_rsp_t want;
    if (rst_ni && done_o) begin
      if (outcome_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, got status %0d held_count %0d",
                 $time, rsp_o.status, rsp_o.held_count);
        mismatches++;
      end else begin
        want = outcome_q.pop_front();
        if (rsp_o.status !== want.status) begin
          $display("%0t: status mismatch: expected %0d, got %0d",
                   $time, want.status, rsp_o.status);
          mismatches++;
        end
        if (rsp_o.held_count !== want.held_count) begin
          $display("%0t: held_count mismatch: expected %0d, got %0d",
                   $time, want.held_count, rsp_o.held_count);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < POOL_SLOTS; i++) slot_used[i] = 1'b0;
    head_at    = NO_LINK;
    tail_at    = NO_LINK;
    cycle_reg  = '0;
    held_total = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < DIR_ROWS; i++) begin
      issue_request(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].rsp, 1'b1);
    end
    for (int k = 0; k < RAND_ITEMS; k++) begin
      // hold off until the block has answered everything
      if (k % DRAIN_EVERY == 0) wait_drained();
      issue_request(random_request(), 1'b0, dir_rows[0].rsp, k < RAND_ITEMS - CALM_ITEMS);
    end
    wait_drained();
    repeat (POOL_SLOTS + 8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
